@@ rtl/cross_entropy_loss_accumulator_top_assert.svh @@
// ----------------------------------------------------------------------------
// cross entropy loss accumulator assertion macros
// implication checks on the rising clock edge, masked while in reset
// ----------------------------------------------------------------------------
`ifndef CROSS_ENTROPY_LOSS_ACCUMULATOR_TOP_ASSERT_SVH
`define CROSS_ENTROPY_LOSS_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define CELA_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define CELA_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define CELA_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define CELA_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

@@ rtl/cela_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cela_pkg
// shared types and constants of the cross entropy loss accumulator
// ----------------------------------------------------------------------------
package cela_pkg;

	localparam int SUM_BITS_DEF = 48;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int TERM_W = 25;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] ONE_Q15 = 16'd32768;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BINARY_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAMPLE_COUNT = 8'd1;

	typedef struct packed {
		logic [15:0] target;
		logic [15:0] prediction;
		logic        last;
	} cela_item_t;

	typedef struct packed {
		logic [31:0] loss;
		logic        saturated;
	} cela_result_t;

	// one classified word between front and back
	typedef struct packed {
		logic signed [TERM_W-1:0] term;
		logic                     last;
	} cela_term_t;

endpackage

@@ rtl/cela_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cela_front
// accepts items and computes the per-item log likelihood term
// ----------------------------------------------------------------------------
module cela_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  cela_pkg::cela_item_t  item,
	input  logic                  binary_mode,
	input  logic                  q_full,
	output logic                  q_push,
	output cela_pkg::cela_term_t  q_data
);
	import cela_pkg::*;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_SQ   = 3'd1;
	localparam logic [2:0] F_LN   = 3'd2;
	localparam logic [2:0] F_MUL  = 3'd3;
	localparam logic [2:0] F_TERM = 3'd4;

	localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;

	function automatic logic [3:0] lead_one(input logic [15:0] m);
		logic [3:0] k;
		k = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (m[i]) k = 4'(i);
		end
		return k;
	endfunction

	logic [2:0] state_q;
	logic [3:0] cnt_q;
	logic [15:0] t_q;
	logic last_q;
	logic [30:0] ya_q, yb_q;
	logic [15:0] fa_q, fb_q;
	logic [4:0] kda_q, kdb_q;
	logic signed [21:0] lna_q, lnb_q;
	logic signed [38:0] pa_q, pb_q;

	logic [15:0] t_c, p_c, ma, mb;
	logic [3:0] ka, kb;
	logic [61:0] sqa, sqb;
	logic [31:0] sa, sb;
	logic signed [20:0] lga, lgb;
	logic signed [52:0] lnpa, lnpb;
	logic [15:0] omt;
	logic signed [39:0] acc;

	assign t_c = (item.target > ONE_Q15) ? ONE_Q15 : item.target;
	assign p_c = (item.prediction > ONE_Q15) ? ONE_Q15 : item.prediction;
	assign ma = p_c + 16'd1;
	assign mb = ONE_Q15 - p_c + 16'd1;
	assign ka = lead_one(ma);
	assign kb = lead_one(mb);

	// mantissa squaring, one fraction bit per cycle
	assign sqa = {31'd0, ya_q} * {31'd0, ya_q};
	assign sqb = {31'd0, yb_q} * {31'd0, yb_q};
	assign sa = sqa[61:30];
	assign sb = sqb[61:30];

	assign lga = $signed({kda_q, fa_q});
	assign lgb = $signed({kdb_q, fb_q});
	assign lnpa = lga * LN2_Q30;
	assign lnpb = lgb * LN2_Q30;

	assign omt = ONE_Q15 - t_q;
	assign acc = {pa_q[38], pa_q} + (binary_mode ? {pb_q[38], pb_q} : 40'sd0);

	assign full = (state_q != F_IDLE);
	assign q_push = (state_q == F_TERM) && !q_full;
	assign q_data.term = acc[39:15];
	assign q_data.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= 4'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						state_q <= F_SQ;
						cnt_q <= 4'd0;
					end
				end
				F_SQ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= F_LN;
				end
				F_LN: state_q <= F_MUL;
				F_MUL: state_q <= F_TERM;
				F_TERM: begin
					if (!q_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				t_q <= t_c;
				last_q <= item.last;
				ya_q <= 31'({15'd0, ma} << (5'd30 - {1'b0, ka}));
				yb_q <= 31'({15'd0, mb} << (5'd30 - {1'b0, kb}));
				kda_q <= {1'b0, ka} - 5'd15;
				kdb_q <= {1'b0, kb} - 5'd15;
				fa_q <= 16'd0;
				fb_q <= 16'd0;
			end
			F_SQ: begin
				ya_q <= sa[31] ? sa[31:1] : sa[30:0];
				yb_q <= sb[31] ? sb[31:1] : sb[30:0];
				fa_q <= {fa_q[14:0], sa[31]};
				fb_q <= {fb_q[14:0], sb[31]};
			end
			F_LN: begin
				lna_q <= lnpa[51:30];
				lnb_q <= lnpb[51:30];
			end
			F_MUL: begin
				pa_q <= $signed({1'b0, t_q}) * lna_q;
				pb_q <= $signed({1'b0, omt}) * lnb_q;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/cela_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cela_fifo
// short word queue between the front and the back
// ----------------------------------------------------------------------------
module cela_fifo #(
	parameter int DEPTH = cela_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  cela_pkg::cela_term_t  wdata,
	input  logic                  pop,
	output logic                  empty,
	output cela_pkg::cela_term_t  rdata
);
	import cela_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cela_term_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + PW'(1);
			if (do_pop) rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + PW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

endmodule

@@ rtl/cela_back.sv @@
`timescale 1ns / 1ps
`include "cross_entropy_loss_accumulator_top_assert.svh"
// ----------------------------------------------------------------------------
// cela_back
// saturating accumulate, batch mean by serial division, result register
// ----------------------------------------------------------------------------
module cela_back #(
	parameter int SUM_BITS = cela_pkg::SUM_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fifo_empty,
	output logic                    fifo_pop,
	input  cela_pkg::cela_term_t    fifo_rdata,
	input  logic [15:0]             sample_count,
	output logic                    empty,
	input  logic                    pop,
	output cela_pkg::cela_result_t  result
);
	import cela_pkg::*;

	localparam int QW = (SUM_BITS > 32) ? SUM_BITS : 33;
	localparam int CNT_W = $clog2(QW + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);
	localparam logic [1:0] B_ACC  = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_HOLD = 2'd2;

	logic [1:0] state_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic ovf_q;
	logic [QW-1:0] dvd_q;
	logic [15:0] rem_q, div_q;
	logic [CNT_W-1:0] cnt_q;
	logic sat_q;
	logic rvalid_q;
	cela_result_t res_q;

	logic signed [SUM_BITS:0] sum_ext;
	logic signed [SUM_BITS-1:0] sum_new;
	logic ovf_add, pos;
	logic [SUM_BITS-1:0] mag;
	logic [16:0] r;
	logic ge;
	logic over;

	assign sum_ext = {sum_q[SUM_BITS-1], sum_q}
		+ {{(SUM_BITS + 1 - TERM_W){fifo_rdata.term[TERM_W-1]}}, fifo_rdata.term};
	assign ovf_add = (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]);
	// clamp toward the side the true sum fell on
	assign sum_new = !ovf_add ? sum_ext[SUM_BITS-1:0]
		: (sum_ext[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
			: {1'b0, {(SUM_BITS - 1){1'b1}}});
	assign pos = !sum_new[SUM_BITS-1] && (sum_new != '0);
	assign mag = '0 - sum_new;

	assign r = {rem_q, dvd_q[QW-1]};
	assign ge = (r >= {1'b0, div_q});
	assign over = |dvd_q[QW-1:32];

	assign fifo_pop = (state_q == B_ACC) && !fifo_empty;
	assign empty = !rvalid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_ACC;
			sum_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (pop && rvalid_q) rvalid_q <= 1'b0;
			unique case (state_q)
				B_ACC: begin
					if (fifo_pop) begin
						if (fifo_rdata.last) begin
							sum_q <= '0;
							ovf_q <= 1'b0;
							cnt_q <= '0;
							state_q <= B_DIV;
						end else begin
							sum_q <= sum_new;
							ovf_q <= ovf_q | ovf_add;
						end
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST_STEP) state_q <= B_HOLD;
				end
				B_HOLD: begin
					if (!rvalid_q) begin
						rvalid_q <= 1'b1;
						state_q <= B_ACC;
					end
				end
				default: state_q <= B_ACC;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_ACC: begin
				dvd_q <= pos ? '0 : QW'(mag);
				rem_q <= 16'd0;
				div_q <= (sample_count == 16'd0) ? 16'd1 : sample_count;
				sat_q <= ovf_q | ovf_add | pos;
			end
			B_DIV: begin
				rem_q <= ge ? 16'(r - {1'b0, div_q}) : r[15:0];
				dvd_q <= {dvd_q[QW-2:0], ge};
			end
			B_HOLD: begin
				if (!rvalid_q) begin
					res_q.loss <= over ? 32'hFFFF_FFFF : dvd_q[31:0];
					res_q.saturated <= sat_q | over;
				end
			end
			default: begin
			end
		endcase
	end

	`CELA_ASSERT_IMP(a_no_pop_in_div, clk, arst_n, state_q == B_DIV, !fifo_pop, "queue popped during division")
	`CELA_ASSERT_NXT(a_last_starts_div, clk, arst_n, fifo_pop && fifo_rdata.last, state_q == B_DIV, "last word did not start division")
	`CELA_ASSERT_NXT(a_hold_loads_result, clk, arst_n, state_q == B_HOLD && !rvalid_q, rvalid_q, "free result register not loaded")

endmodule

@@ rtl/cross_entropy_loss_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_entropy_loss_accumulator_top
// binary and categorical cross entropy loss over a batch of items
// ----------------------------------------------------------------------------
// each item (target, prediction in unsigned Q1.15) adds t*ln(p+eps), plus
// (1-t)*ln(1-p+eps) in binary mode, to a saturating signed Q.16 sum; the
// item marked last emits the negated sum over sample_count as unsigned
// Q16.16 with a saturated flag and clears the sum. the front takes one item
// at a time: a capture step, the mantissa squaring loop in its log unit,
// then ln scaling, product and term steps; the term step waits while the
// queue is full. a last item additionally occupies the back for the
// bit-serial divider and the result load, which waits while the result
// register is full; the queue lets the front keep working on the next batch
// meanwhile. configuration writes are always ready and take effect at once.
module cross_entropy_loss_accumulator_top #(
	parameter int SUM_BITS = cela_pkg::SUM_BITS_DEF,
	parameter int QUEUE_DEPTH = cela_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item side
	input  logic                              push,
	output logic                              full,
	input  cela_pkg::cela_item_t              item,
	// result side
	output logic                              empty,
	input  logic                              pop,
	output cela_pkg::cela_result_t            result,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cela_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cela_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cela_pkg::*;

	logic binary_mode_q;
	logic [15:0] sample_count_q;

	// front to queue and queue to back word
	logic q_full, q_push, q_empty, q_pop;
	cela_term_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q <= 1'b1;
			sample_count_q <= 16'd1;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IDX_BINARY_MODE) binary_mode_q <= cfg_data[0];
			if (cfg_index == CFG_IDX_SAMPLE_COUNT) sample_count_q <= cfg_data;
		end
	end

	// log terms
	cela_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.binary_mode (binary_mode_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	// decoupling queue
	cela_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	// accumulate, divide, hold the result word
	cela_back #(
		.SUM_BITS (SUM_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (q_empty),
		.fifo_pop     (q_pop),
		.fifo_rdata   (q_rdata),
		.sample_count (sample_count_q),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule
